@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks in the projection pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, masked while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, including reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lpp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpp_pkg
// Constants, register indexes and fixed-point helpers for the projection.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    localparam int ROT_FRAC  = 17;
    localparam int COEF_FRAC = 15;
    localparam int NORM_FRAC = 20;
    localparam int QBITS     = 23;   // Q3.20 quotient magnitude

    localparam int MIN_DEPTH = 1024;
    localparam logic signed [46:0] DEPTH_THRESH = 47'(MIN_DEPTH) <<< ROT_FRAC;
    localparam logic [QBITS-1:0]   NORM_LIMIT   = {QBITS{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PP    = 3'd7;

    localparam logic [CFG_W-1:0] ROT0_RST  = 60'd131072;
    localparam logic [CFG_W-1:0] ROT1_RST  = 60'd137438953472;
    localparam logic [CFG_W-1:0] ROT2_RST  = 60'd144115188075855872;
    localparam logic [CFG_W-1:0] FOCAL_RST = 60'd35184372121600;

    // Arithmetic shift right that rounds toward zero.
    function automatic logic signed [63:0] tz64(input logic signed [63:0] a,
                                                input int unsigned s);
        logic signed [63:0] bias;
        bias = a[63] ? ((64'sd1 <<< s) - 64'sd1) : 64'sd0;
        return (a + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (a < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return a[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] a);
        if (a > 64'sd32767) begin
            return 16'sh7fff;
        end else if (a < -64'sd32768) begin
            return 16'sh8000;
        end
        return a[15:0];
    endfunction

endpackage

@@ rtl/lidar_point_to_pixel_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projection
// Pinhole projection of lidar points to camera pixels with lens distortion.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one lidar point per word (x, y, z, 1/1024 m). m_ channel
//   returns one pixel word (u, v, forward distance) for each point whose camera
//   depth is above 1 m; points at or behind that depth are dropped silently.
//   Throughput is one point per clock unless a stalled output word fills the
//   pipeline. The 41 stages are input, subtract, rotate multiply, sum, depth
//   check, 23 restoring divider stages (one quotient bit each, x and y side
//   by side), and 13 distortion and scaling stages with a register after
//   every multiplier.
//   Each stage holds its own valid bit and advances whenever the stage after
//   it is free, so bubbles collapse and s_tready stays high while m_ waits,
//   until the pipeline is full behind the stalled output word.
//   Reset (aresetn low at a clock edge) empties the pipeline and loads the
//   default calibration: identity rotation, zero offset, unit focal length.
//   Write configuration through cfg_wr_* only while no point is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_point_to_pixel_projection (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // point_x[23:0], point_y[47:24], point_z[71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,      // pixel_u[15:0], pixel_v[31:16], fwd[55:32]
    input  logic        cfg_wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [lpp_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int LAST = 40;   // output stage
    localparam int DIV0 = 5;    // first divider stage
    localparam int DIVL = 27;   // last divider stage

    // ---------------- configuration registers ----------------
    logic [lpp_pkg::CFG_W-1:0] rot_reg [3];
    logic [lpp_pkg::CFG_W-1:0] trans_reg, radc_reg, tanc_reg, focal_reg, pp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0] <= lpp_pkg::ROT0_RST;
            rot_reg[1] <= lpp_pkg::ROT1_RST;
            rot_reg[2] <= lpp_pkg::ROT2_RST;
            trans_reg  <= '0;
            radc_reg   <= '0;
            tanc_reg   <= '0;
            focal_reg  <= lpp_pkg::FOCAL_RST;
            pp_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                lpp_pkg::REG_ROT0:  rot_reg[0] <= cfg_wr_data;
                lpp_pkg::REG_ROT1:  rot_reg[1] <= cfg_wr_data;
                lpp_pkg::REG_ROT2:  rot_reg[2] <= cfg_wr_data;
                lpp_pkg::REG_TRANS: trans_reg  <= cfg_wr_data;
                lpp_pkg::REG_RAD:   radc_reg   <= cfg_wr_data;
                lpp_pkg::REG_TAN:   tanc_reg   <= cfg_wr_data;
                lpp_pkg::REG_FOCAL: focal_reg  <= cfg_wr_data;
                lpp_pkg::REG_PP:    pp_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Unpack calibration fields.
    logic signed [19:0] rot_e [3][3];   // [row][element]
    logic signed [19:0] tr_e  [3];
    logic signed [19:0] k1, k2, k3, p1, p2;
    logic signed [29:0] fx, fy, cx, cy;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int e = 0; e < 3; e++) begin
                rot_e[r][e] = rot_reg[r][20*e +: 20];
            end
            tr_e[r] = trans_reg[20*r +: 20];
        end
        k1 = radc_reg[19:0];
        k2 = radc_reg[39:20];
        k3 = radc_reg[59:40];
        p1 = tanc_reg[19:0];
        p2 = tanc_reg[39:20];
        fx = focal_reg[29:0];
        fy = focal_reg[59:30];
        cx = pp_reg[29:0];
        cy = pp_reg[59:30];
    end

    // ---------------- stage handshake ----------------
    // A stage loads when it is empty or when the stage after it loads.
    logic vld_reg [0:LAST];
    logic en      [0:LAST];
    logic keep_reg [4:LAST-1];   // point is in front of the camera

    always_comb begin
        en[LAST] = !vld_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < LAST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            // Drop points at or behind the depth limit here.
            if (en[LAST]) begin
                vld_reg[LAST] <= vld_reg[LAST-1] && keep_reg[LAST-1];
            end
        end
    end

    // ---------------- stages 0..4: camera frame ----------------
    logic signed [23:0] pin_reg [3];
    logic signed [23:0] fwd_reg [0:LAST];
    logic signed [24:0] d_reg   [3];
    logic signed [44:0] m_reg   [3][3];   // [camera axis][lidar axis]
    logic signed [46:0] c_reg   [3];

    logic [46:0] dd_reg   [4:DIVL];
    logic [47:0] rx_reg   [4:DIVL];
    logic [47:0] ry_reg   [4:DIVL];
    logic [lpp_pkg::QBITS-1:0] qx_reg [4:DIVL];
    logic [lpp_pkg::QBITS-1:0] qy_reg [4:DIVL];
    logic negx_reg [4:DIVL];
    logic negy_reg [4:DIVL];
    logic satx_reg [4:DIVL];
    logic saty_reg [4:DIVL];

    logic [46:0] nx_abs, ny_abs;

    always_comb begin
        nx_abs = c_reg[0][46] ? 47'(-c_reg[0]) : 47'(c_reg[0]);
        ny_abs = c_reg[1][46] ? 47'(-c_reg[1]) : 47'(c_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pin_reg[0] <= s_tdata[23:0];
            pin_reg[1] <= s_tdata[47:24];
            pin_reg[2] <= s_tdata[71:48];
        end
        if (en[1]) begin
            for (int j = 0; j < 3; j++) begin
                d_reg[j] <= 25'(pin_reg[j]) - 25'(tr_e[j]);
            end
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    m_reg[i][j] <= rot_e[j][i] * d_reg[j];
                end
            end
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= 47'(m_reg[i][0]) + 47'(m_reg[i][1]) + 47'(m_reg[i][2]);
            end
        end
        if (en[4]) begin
            dd_reg[4]   <= c_reg[2];
            rx_reg[4]   <= {1'b0, nx_abs};
            ry_reg[4]   <= {1'b0, ny_abs};
            qx_reg[4]   <= '0;
            qy_reg[4]   <= '0;
            negx_reg[4] <= c_reg[0][46];
            negy_reg[4] <= c_reg[1][46];
            satx_reg[4] <= {3'b0, nx_abs} >= {c_reg[2], 3'b0};
            saty_reg[4] <= {3'b0, ny_abs} >= {c_reg[2], 3'b0};
        end
    end

    // ---------------- stages 5..27: restoring division ----------------
    // First three steps give the integer bits, the rest one fraction bit each.
    for (genvar k = DIV0; k <= DIVL; k++) begin : g_div
        localparam int S = k - DIV0;
        logic [49:0] dsh, xcur, ycur, xdif, ydif;
        logic        xge, yge;

        if (S < 3) begin : g_int
            localparam int B = 2 - S;
            assign dsh  = {3'b0, dd_reg[k-1]} << B;
            assign xcur = {2'b0, rx_reg[k-1]};
            assign ycur = {2'b0, ry_reg[k-1]};
        end else begin : g_frac
            assign dsh  = {3'b0, dd_reg[k-1]};
            assign xcur = {1'b0, rx_reg[k-1], 1'b0};
            assign ycur = {1'b0, ry_reg[k-1], 1'b0};
        end

        assign xge  = xcur >= dsh;
        assign yge  = ycur >= dsh;
        assign xdif = xcur - dsh;
        assign ydif = ycur - dsh;

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rx_reg[k]   <= xge ? xdif[47:0] : xcur[47:0];
                ry_reg[k]   <= yge ? ydif[47:0] : ycur[47:0];
                qx_reg[k]   <= {qx_reg[k-1][lpp_pkg::QBITS-2:0], xge};
                qy_reg[k]   <= {qy_reg[k-1][lpp_pkg::QBITS-2:0], yge};
                dd_reg[k]   <= dd_reg[k-1];
                negx_reg[k] <= negx_reg[k-1];
                negy_reg[k] <= negy_reg[k-1];
                satx_reg[k] <= satx_reg[k-1];
                saty_reg[k] <= saty_reg[k-1];
            end
        end
    end

    // ---------------- stages 28..40: distortion and scaling ----------------
    logic signed [23:0] xn_reg [28:36];
    logic signed [23:0] yn_reg [28:36];
    logic signed [47:0] pxx_reg, pyy_reg, pxy_reg;
    logic [25:0]        x2_reg, y2_reg;
    logic signed [26:0] xy_reg;
    logic [26:0]        r2_reg [30:32];
    logic [53:0]        pr4_reg;
    logic signed [47:0] mk1_reg;
    logic signed [46:0] mp1xy_reg, mp2xy_reg;
    logic [27:0]        sx_reg [31:32];
    logic [27:0]        sy_reg [31:32];
    logic [33:0]        r4_reg;
    logic signed [32:0] tk1_reg  [32:35];
    logic signed [32:0] txy1_reg [32:37];
    logic signed [32:0] txy2_reg [32:37];
    logic [60:0]        pr6_reg;
    logic signed [54:0] mk2_reg;
    logic signed [48:0] mp2sx_reg, mp1sy_reg;
    logic [40:0]        r6_reg;
    logic signed [39:0] tk2_reg [34:35];
    logic signed [33:0] tsx_reg [34:37];
    logic signed [33:0] tsy_reg [34:37];
    logic signed [61:0] mk3_reg;
    logic signed [31:0] rad_reg;
    logic signed [55:0] mxr_reg, myr_reg;
    logic signed [31:0] xd_reg, yd_reg;
    logic signed [61:0] mfx_reg, mfy_reg;
    logic signed [15:0] u_reg, v_reg;

    logic signed [23:0] xn_next, yn_next;
    logic [46:0]        r2sum;
    logic signed [63:0] t_xy, t_k1, t_xy1, t_xy2, t_k2, t_sx, t_sy, t_k3;
    logic signed [63:0] t_xr, t_yr, t_fx, t_fy, t_u, t_v;

    always_comb begin
        xn_next = satx_reg[DIVL] ? 24'($signed({1'b0, lpp_pkg::NORM_LIMIT}))
                                 : 24'($signed({1'b0, qx_reg[DIVL]}));
        yn_next = saty_reg[DIVL] ? 24'($signed({1'b0, lpp_pkg::NORM_LIMIT}))
                                 : 24'($signed({1'b0, qy_reg[DIVL]}));
        if (negx_reg[DIVL]) begin
            xn_next = -xn_next;
        end
        if (negy_reg[DIVL]) begin
            yn_next = -yn_next;
        end

        r2sum = pxx_reg[46:0] + pyy_reg[46:0];
        t_xy  = lpp_pkg::tz64(pxy_reg, lpp_pkg::NORM_FRAC);
        t_k1  = lpp_pkg::tz64(mk1_reg, lpp_pkg::COEF_FRAC);
        t_xy1 = lpp_pkg::tz64(64'(mp1xy_reg) <<< 1, lpp_pkg::COEF_FRAC);
        t_xy2 = lpp_pkg::tz64(64'(mp2xy_reg) <<< 1, lpp_pkg::COEF_FRAC);
        t_k2  = lpp_pkg::tz64(mk2_reg, lpp_pkg::COEF_FRAC);
        t_sx  = lpp_pkg::tz64(mp2sx_reg, lpp_pkg::COEF_FRAC);
        t_sy  = lpp_pkg::tz64(mp1sy_reg, lpp_pkg::COEF_FRAC);
        t_k3  = lpp_pkg::tz64(mk3_reg, lpp_pkg::COEF_FRAC);
        t_xr  = lpp_pkg::tz64(mxr_reg, lpp_pkg::NORM_FRAC);
        t_yr  = lpp_pkg::tz64(myr_reg, lpp_pkg::NORM_FRAC);
        t_fx  = lpp_pkg::tz64(mfx_reg, lpp_pkg::NORM_FRAC) + 64'(cx);
        t_fy  = lpp_pkg::tz64(mfy_reg, lpp_pkg::NORM_FRAC) + 64'(cy);
        t_u   = lpp_pkg::tz64(t_fx, lpp_pkg::COEF_FRAC);
        t_v   = lpp_pkg::tz64(t_fy, lpp_pkg::COEF_FRAC);
    end

    always_ff @(posedge aclk) begin
        if (en[28]) begin
            xn_reg[28] <= xn_next;
            yn_reg[28] <= yn_next;
        end
        if (en[29]) begin
            pxx_reg <= xn_reg[28] * xn_reg[28];
            pyy_reg <= yn_reg[28] * yn_reg[28];
            pxy_reg <= xn_reg[28] * yn_reg[28];
        end
        if (en[30]) begin
            x2_reg     <= pxx_reg[45:20];
            y2_reg     <= pyy_reg[45:20];
            xy_reg     <= t_xy[26:0];
            r2_reg[30] <= r2sum[46:20];
        end
        if (en[31]) begin
            pr4_reg    <= r2_reg[30] * r2_reg[30];
            mk1_reg    <= k1 * $signed({1'b0, r2_reg[30]});
            mp1xy_reg  <= p1 * xy_reg;
            mp2xy_reg  <= p2 * xy_reg;
            sx_reg[31] <= 28'(r2_reg[30]) + {1'b0, x2_reg, 1'b0};
            sy_reg[31] <= 28'(r2_reg[30]) + {1'b0, y2_reg, 1'b0};
        end
        if (en[32]) begin
            r4_reg       <= pr4_reg[53:20];
            tk1_reg[32]  <= t_k1[32:0];
            txy1_reg[32] <= t_xy1[32:0];
            txy2_reg[32] <= t_xy2[32:0];
        end
        if (en[33]) begin
            pr6_reg   <= r4_reg * r2_reg[32];
            mk2_reg   <= k2 * $signed({1'b0, r4_reg});
            mp2sx_reg <= p2 * $signed({1'b0, sx_reg[32]});
            mp1sy_reg <= p1 * $signed({1'b0, sy_reg[32]});
        end
        if (en[34]) begin
            r6_reg      <= pr6_reg[60:20];
            tk2_reg[34] <= t_k2[39:0];
            tsx_reg[34] <= t_sx[33:0];
            tsy_reg[34] <= t_sy[33:0];
        end
        if (en[35]) begin
            mk3_reg <= k3 * $signed({1'b0, r6_reg});
        end
        if (en[36]) begin
            rad_reg <= lpp_pkg::sat32((64'sd1 <<< lpp_pkg::NORM_FRAC) + 64'(tk1_reg[35])
                                      + 64'(tk2_reg[35]) + t_k3);
        end
        if (en[37]) begin
            mxr_reg <= xn_reg[36] * rad_reg;
            myr_reg <= yn_reg[36] * rad_reg;
        end
        if (en[38]) begin
            xd_reg <= lpp_pkg::sat32(t_xr + 64'(txy1_reg[37]) + 64'(tsx_reg[37]));
            yd_reg <= lpp_pkg::sat32(t_yr + 64'(tsy_reg[37]) + 64'(txy2_reg[37]));
        end
        if (en[39]) begin
            mfx_reg <= fx * xd_reg;
            mfy_reg <= fy * yd_reg;
        end
        if (en[LAST]) begin
            u_reg <= lpp_pkg::sat16(t_u);
            v_reg <= lpp_pkg::sat16(t_v);
        end

        // Shift carried values along with their point.
        if (en[0]) fwd_reg[0] <= s_tdata[23:0];
        if (en[4]) keep_reg[4] <= c_reg[2] > lpp_pkg::DEPTH_THRESH;
        for (int k = 1; k <= LAST; k++) begin
            if (en[k]) fwd_reg[k] <= fwd_reg[k-1];
        end
        for (int k = 5; k < LAST; k++) begin
            if (en[k]) keep_reg[k] <= keep_reg[k-1];
        end
        for (int k = 29; k <= 36; k++) begin
            if (en[k]) begin
                xn_reg[k] <= xn_reg[k-1];
                yn_reg[k] <= yn_reg[k-1];
            end
        end
        for (int k = 31; k <= 32; k++) begin
            if (en[k]) r2_reg[k] <= r2_reg[k-1];
        end
        if (en[32]) begin
            sx_reg[32] <= sx_reg[31];
            sy_reg[32] <= sy_reg[31];
        end
        for (int k = 33; k <= 35; k++) begin
            if (en[k]) tk1_reg[k] <= tk1_reg[k-1];
        end
        for (int k = 33; k <= 37; k++) begin
            if (en[k]) begin
                txy1_reg[k] <= txy1_reg[k-1];
                txy2_reg[k] <= txy2_reg[k-1];
            end
        end
        if (en[35]) tk2_reg[35] <= tk2_reg[34];
        for (int k = 35; k <= 37; k++) begin
            if (en[k]) begin
                tsx_reg[k] <= tsx_reg[k-1];
                tsy_reg[k] <= tsy_reg[k-1];
            end
        end
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {fwd_reg[LAST], v_reg, u_reg};

    // ---------------- checks ----------------
    `ASSERT_RST(a_div_rem, aclk, aresetn,
        vld_reg[DIVL] && keep_reg[DIVL] && !satx_reg[DIVL] |-> rx_reg[DIVL] < {1'b0, dd_reg[DIVL]},
        "divider remainder not below the depth")
    `ASSERT_RST(a_stall_src, aclk, aresetn,
        !s_tready |-> m_tvalid && !m_tready,
        "input held off without a stalled output word")
    `ASSERT_ALWAYS(a_rst_empty, aclk,
        !aresetn |=> !m_tvalid,
        "output word valid right after reset")

endmodule

@@ verif/lidar_point_to_pixel_projection_test.sv @@
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projection_test
// Streams lidar points through the projection block under several camera
// calibrations and random handshake pressure. Each pixel word is checked
// against a bit-exact fixed-point projection computed in the scoreboard.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projection_test;

    typedef struct packed {
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic signed [23:0] fwd;
    } pixel_t;

    // Pixel scoreboard: holds a copy of the calibration and the pixels owed.
    class pixel_scoreboard;
        logic [lpp_pkg::CFG_W-1:0] calib [8];
        pixel_t owed [$];
        int errors;

        function void load_defaults();
            foreach (calib[i]) calib[i] = '0;
            calib[lpp_pkg::REG_ROT0]  = lpp_pkg::ROT0_RST;
            calib[lpp_pkg::REG_ROT1]  = lpp_pkg::ROT1_RST;
            calib[lpp_pkg::REG_ROT2]  = lpp_pkg::ROT2_RST;
            calib[lpp_pkg::REG_FOCAL] = lpp_pkg::FOCAL_RST;
        endfunction

        function longint field(logic [lpp_pkg::CFG_W-1:0] r, int idx, int w);
            longint v;
            v = longint'((r >> (idx * w)) & ((60'd1 << w) - 60'd1));
            if (v[w-1]) v = v - (longint'(1) << w);
            return v;
        endfunction

        function longint trunc_shift(longint a, int s);
            longint m;
            m = (a < 0) ? -a : a;
            m = m >> s;
            return (a < 0) ? -m : m;
        endfunction

        function longint clamp(longint a, longint lo, longint hi);
            return (a < lo) ? lo : ((a > hi) ? hi : a);
        endfunction

        // Depth ratio in Q3.20, truncated toward zero, saturated.
        function longint ratio(longint num, longint den);
            logic [127:0] mag;
            longint q;
            mag = (num < 0) ? 128'(-num) : 128'(num);
            if (mag >= 128'(8 * den))
                q = (longint'(8) << 20) - 1;
            else
                q = longint'((mag << 20) / 128'(den));
            return (num < 0) ? -q : q;
        endfunction

        function longint to_pixel(longint f, longint xd, longint c);
            longint v;
            v = trunc_shift(f * xd, 20) + c;
            return clamp(trunc_shift(v, 15), -32768, 32767);
        endfunction

        // Returns 1 if the point lands in front of the camera.
        function bit project(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                             output pixel_t pix);
            longint dd [3], cc [3], p [3];
            longint xn, yn, x2, y2, xy, r2, r4, r6, rad, xd, yd;
            longint k1, k2, k3, p1, p2;
            p[0] = longint'(signed'(px));
            p[1] = longint'(signed'(py));
            p[2] = longint'(signed'(pz));
            pix = '0;
            for (int j = 0; j < 3; j++)
                dd[j] = p[j] - field(calib[lpp_pkg::REG_TRANS], j, 20);
            for (int i = 0; i < 3; i++) begin
                cc[i] = 0;
                for (int j = 0; j < 3; j++) cc[i] += field(calib[j], i, 20) * dd[j];
            end
            if (cc[2] <= (longint'(lpp_pkg::MIN_DEPTH) << 17)) return 0;
            xn = ratio(cc[0], cc[2]);
            yn = ratio(cc[1], cc[2]);
            k1 = field(calib[lpp_pkg::REG_RAD], 0, 20);
            k2 = field(calib[lpp_pkg::REG_RAD], 1, 20);
            k3 = field(calib[lpp_pkg::REG_RAD], 2, 20);
            p1 = field(calib[lpp_pkg::REG_TAN], 0, 20);
            p2 = field(calib[lpp_pkg::REG_TAN], 1, 20);
            x2 = trunc_shift(xn * xn, 20);
            y2 = trunc_shift(yn * yn, 20);
            xy = trunc_shift(xn * yn, 20);
            r2 = trunc_shift(xn * xn + yn * yn, 20);
            r4 = trunc_shift(r2 * r2, 20);
            r6 = trunc_shift(r4 * r2, 20);
            rad = (longint'(1) << 20) + trunc_shift(k1 * r2, 15)
                + trunc_shift(k2 * r4, 15) + trunc_shift(k3 * r6, 15);
            rad = clamp(rad, -64'sd2147483648, 64'sd2147483647);
            xd = trunc_shift(xn * rad, 20) + trunc_shift(2 * p1 * xy, 15)
               + trunc_shift(p2 * (r2 + 2 * x2), 15);
            yd = trunc_shift(yn * rad, 20) + trunc_shift(p1 * (r2 + 2 * y2), 15)
               + trunc_shift(2 * p2 * xy, 15);
            xd = clamp(xd, -64'sd2147483648, 64'sd2147483647);
            yd = clamp(yd, -64'sd2147483648, 64'sd2147483647);
            pix.u   = 16'(to_pixel(field(calib[lpp_pkg::REG_FOCAL], 0, 30), xd,
                                   field(calib[lpp_pkg::REG_PP], 0, 30)));
            pix.v   = 16'(to_pixel(field(calib[lpp_pkg::REG_FOCAL], 1, 30), yd,
                                   field(calib[lpp_pkg::REG_PP], 1, 30)));
            pix.fwd = px;
            return 1;
        endfunction

        function void note_point(logic [71:0] word);
            pixel_t pix;
            if (project(word[23:0], word[47:24], word[71:48], pix)) owed = {owed, pix};
        endfunction

        task report_mismatch(string what, logic [55:0] got, logic [55:0] want);
            $display("MISMATCH %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_pixel(logic [55:0] word);
            pixel_t want;
            if (owed.size() == 0) begin
                report_mismatch("unexpected pixel word", word, '0);
                return;
            end
            want = owed.pop_front();
            if (word[15:0] !== want.u)
                report_mismatch("pixel_u", word, {want.fwd, want.v, want.u});
            if (word[31:16] !== want.v)
                report_mismatch("pixel_v", word, {want.fwd, want.v, want.u});
            if (word[55:32] !== want.fwd)
                report_mismatch("forward_distance", word, {want.fwd, want.v, want.u});
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;       // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // pixel_u, pixel_v, forward_distance
    logic        cfg_wr_en = 1'b0;
    logic [lpp_pkg::CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [lpp_pkg::CFG_W-1:0]     cfg_wr_data = '0;

    pixel_scoreboard board = new();
    int tx_idle = 34;
    int rx_idle = 52;
    int sent = 0;
    longint cycles = 0;

    lidar_point_to_pixel_projection dut (.*);

    always #10 aclk = ~aclk;

    // Watchdog: far beyond the slowest legal run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("lidar_point_to_pixel_projection test failed");
            $finish;
        end
    end

    // Random back pressure on the pixel side.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Note accepted points and check accepted pixels at the same edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_point(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata);
    end

    function automatic logic [59:0] pack3(logic signed [31:0] a, logic signed [31:0] b,
                                          logic signed [31:0] c);
        return {c[19:0], b[19:0], a[19:0]};
    endfunction

    function automatic logic [59:0] pack2(logic signed [31:0] a, logic signed [31:0] b);
        return {b[29:0], a[29:0]};
    endfunction

    // Send one point; hold tvalid high into the next point unless idling.
    task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (sent == 500) begin
            tx_idle = 52;
            rx_idle = 34;
        end else if (sent == 1000) begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    // Drain the pipeline, including dropped points still in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_calibration(logic [59:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= i[lpp_pkg::CFG_IDX_W-1:0];
            cfg_wr_data  <= vals[i];
            board.calib[i] = vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'(signed'(16'($urandom)));
            2: return 24'(signed'(12'($urandom)));
            default: return 24'($urandom_range(9000));
        endcase
    endfunction

    task automatic directed_points();
        send_point(24'd0, 24'd0, 24'd1024);            // exactly at min depth: dropped
        send_point(24'd0, 24'd0, 24'd1025);
        send_point(24'd1025, 24'd0, 24'd0);
        send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h7fffff, 24'h800000, 24'd2000);   // far off axis, ratio saturates
        send_point(24'h800000, 24'h7fffff, 24'd2000);
        send_point(24'd5000, 24'hffec78, 24'd1100);
        send_point(24'd300, 24'd200, 24'd4096);
        send_point(24'h000000, 24'hffffff, 24'h7fffff);
    endtask

    // Mostly points that project; some raw noise that may be dropped.
    task automatic random_points(int count);
        logic [23:0] x, y, z;
        pixel_t pix;
        for (int n = 0; n < count; n++) begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            if ($urandom_range(99) < 75) begin
                for (int t = 0; t < 12 && !board.project(x, y, z, pix); t++) begin
                    x = rand_coord();
                    y = rand_coord();
                    z = rand_coord();
                end
            end
            send_point(x, y, z);
        end
    endtask

    initial begin
        logic [59:0] cal [8];
        board.load_defaults();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    // lidar forward becomes camera depth, a typical lens
                    cal[lpp_pkg::REG_ROT0]  = pack3(0, 0, 1 << 17);
                    cal[lpp_pkg::REG_ROT1]  = pack3(-(1 << 17), 0, 0);
                    cal[lpp_pkg::REG_ROT2]  = pack3(0, -(1 << 17), 0);
                    cal[lpp_pkg::REG_TRANS] = pack3(100, -50, 200);
                    cal[lpp_pkg::REG_RAD]   = pack3(-9830, 3277, -500);
                    cal[lpp_pkg::REG_TAN]   = pack3(33, -66, 0);
                    cal[lpp_pkg::REG_FOCAL] = pack2(700 << 15, 700 << 15);
                    cal[lpp_pkg::REG_PP]    = pack2(640 << 15, 360 << 15);
                end
                2: begin
                    foreach (cal[i]) cal[i] = 60'({$urandom, $urandom});
                end
                3: begin
                    foreach (cal[i]) cal[i] = pack3(32'h7ffff, 32'h7ffff, 32'h7ffff);
                    cal[lpp_pkg::REG_TRANS] = pack3(-524288, -524288, -524288);
                    cal[lpp_pkg::REG_FOCAL] = pack2(32'h1fffffff, 32'h1fffffff);
                    cal[lpp_pkg::REG_PP]    = pack2(32'h1fffffff, 32'h1fffffff);
                end
                4: begin
                    foreach (cal[i]) cal[i] = pack3(-524288, -524288, -524288);
                    cal[lpp_pkg::REG_ROT2]  = pack3(0, 0, 1 << 17);
                    cal[lpp_pkg::REG_TRANS] = '0;
                    cal[lpp_pkg::REG_FOCAL] = pack2(32'he0000000, 32'he0000000);
                    cal[lpp_pkg::REG_PP]    = pack2(32'he0000000, 32'he0000000);
                end
                default: ;
            endcase
            if (phase != 0) write_calibration(cal);
            directed_points();
            random_points(290);
            drain();
        end

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("lidar_point_to_pixel_projection test passed");
        end else begin
            $display("lidar_point_to_pixel_projection test failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/lpp_pkg.sv
rtl/lidar_point_to_pixel_projection.sv
verif/lidar_point_to_pixel_projection_test.sv
